>>> sv/tcce_pkg.sv
// Shared types, codes and helpers for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

   localparam int COORD_MAX = 4095;
   localparam int EXTENT_MAX = 4096;
   localparam int TAB_STEP = 8;
   localparam logic [7:0] PRINT_MIN = 8'h20;

   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic [2:0] REG_TEXT_COLS = 3'd0;
   localparam logic [2:0] REG_TEXT_ROWS = 3'd1;
   localparam logic [2:0] REG_SCREEN_WIDTH = 3'd2;
   localparam logic [2:0] REG_CONSOLE_ENABLE = 3'd3;
   localparam logic [2:0] REG_FG_COLOR = 3'd4;
   localparam logic [2:0] REG_BG_COLOR = 3'd5;

   localparam logic MODE_PUT = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      KIND_GLYPH = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_PRESENT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [12:0] left;
      logic [12:0] top;
      logic [12:0] right;
      logic [12:0] bottom;
   } rect_type;

   typedef struct packed {
      kind_type kind;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [12:0] rect_w;
      logic [12:0] rect_h;
      logic [7:0] glyph;
      logic [23:0] fore;
      logic [23:0] back;
      logic last;
   } cmd_type;

   function automatic logic rect_empty(rect_type d);
      return (d.right <= d.left) || (d.bottom <= d.top);
   endfunction

   function automatic rect_type rect_grow(rect_type d, rect_type r);
      rect_type g;
      g = d;
      if (rect_empty(d)) begin
         g = r;
      end else begin
         if (r.left < d.left) g.left = r.left;
         if (r.top < d.top) g.top = r.top;
         if (r.right > d.right) g.right = r.right;
         if (r.bottom > d.bottom) g.bottom = r.bottom;
      end
      return g;
   endfunction

endpackage

>>> sv/text_console_cursor_engine.sv
// Text console cursor engine: cursor, dirty rectangle and command queue.
//
// Usage: character bytes (req_tuser = 0) or flush requests (req_tuser = 1)
// enter on the req_ stream. Each transaction yields zero, one or two drawing
// commands on the rsp_ stream: draw glyph, scroll up one line, or present the
// dirty rectangle; rsp_tlast marks the final command of a transaction.
// The user must write configuration registers on the csr_ port only while the block is idle;
// the block itself does not enforce it. Commands pass through the registered output queue to rsp_.
// Throughput: one transaction per cycle while each gives at most one command
// and the receiver takes every command; a transaction that gives two commands
// is held back by the single command per cycle that the output queue delivers.
// The output queue holds three commands; req_tready is high while it holds
// at most one, so the input keeps flowing while a result waits to be taken.
// When the receiver stalls, commands hold in the queue and req_tready drops
// once two are waiting.
// Reset: cursor at the top left, empty dirty rectangle, empty queue,
// registers at their defaults (console disabled).
`timescale 1ns / 1ps

module text_console_cursor_engine #(
   parameter int CELL_W = 8,
   parameter int CELL_H = 16,
   parameter int BORDER = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_code
   input  logic req_tuser,          // [0] mode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [11:0] pos_x, [23:12] pos_y, [36:24] rect_w, [49:37] rect_h,
   // [57:50] glyph, [81:58] fore, [105:82] back, [111:106] zero
   output logic [111:0] rsp_tdata,
   output tcce_pkg::kind_type rsp_tuser,  // [1:0] kind
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_wdata
);
   import tcce_pkg::*;

   localparam int CELL_MAX = (CELL_W > CELL_H) ? CELL_W : CELL_H;
   localparam int COORD_RAW = $clog2(BORDER + 256 * CELL_MAX + 1);
   localparam int COORD_W = (COORD_RAW > 14) ? COORD_RAW : 14;

   logic [7:0] text_cols_ff, text_rows_ff;
   logic [12:0] screen_width_ff;
   logic console_enable_ff;
   logic [23:0] fg_color_ff, bg_color_ff;

   logic [7:0] caret_col_ff, caret_col_in;
   logic [7:0] caret_row_ff, caret_row_in;
   rect_type dirty_ff, dirty_in;

   cmd_type queue_ff [3];
   cmd_type queue_in [3];
   logic [1:0] count_ff, count_in;

   logic accept, pop, put_active, flush_req;
   logic [8:0] cols_eff, rows_eff;
   logic [8:0] col_a;
   logic [9:0] row_a, row_b;
   logic [8:0] col_b;
   logic glyph_en, scroll_en, present_en, ignore, is_lf;
   logic [COORD_W-1:0] rx, ry, rx_end, ry_end, scroll_h, scroll_bot;
   logic [12:0] scroll_w;
   rect_type glyph_rect, scroll_rect, d1, d2, pres_rect;
   cmd_type c_glyph, c_scroll, c_present, c0, c1;
   logic [1:0] n_cmd, base;

   assign accept = req_tvalid && req_tready;
   assign pop = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= 2'd1);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser = queue_ff[0].kind;
   assign rsp_tlast = queue_ff[0].last;
   assign rsp_tdata = {6'd0, queue_ff[0].back, queue_ff[0].fore, queue_ff[0].glyph,
                       queue_ff[0].rect_h, queue_ff[0].rect_w, queue_ff[0].pos_y,
                       queue_ff[0].pos_x};

   assign flush_req = (req_tuser == MODE_FLUSH);
   assign cols_eff = {1'b0, (text_cols_ff == 8'd0) ? 8'd1 : text_cols_ff};
   assign rows_eff = {1'b0, (text_rows_ff == 8'd0) ? 8'd1 : text_rows_ff};

   always_comb begin
      col_a = {1'b0, caret_col_ff};
      row_a = {2'b00, caret_row_ff};
      glyph_en = 1'b0;
      ignore = 1'b0;
      is_lf = 1'b0;
      case (req_tdata)
         CHAR_LF: begin
            col_a = 9'd0;
            row_a = {2'b00, caret_row_ff} + 10'd1;
            is_lf = 1'b1;
         end
         CHAR_CR: begin
            col_a = 9'd0;
         end
         CHAR_TAB: begin
            col_a = ({1'b0, caret_col_ff} + 9'(TAB_STEP)) & ~9'(TAB_STEP - 1);
         end
         CHAR_BS: begin
            if (caret_col_ff != 8'd0) col_a = {1'b0, caret_col_ff} - 9'd1;
         end
         default: begin
            if (req_tdata < PRINT_MIN) begin
               ignore = 1'b1;
            end else begin
               glyph_en = 1'b1;
               col_a = {1'b0, caret_col_ff} + 9'd1;
            end
         end
      endcase

      put_active = !flush_req && console_enable_ff && !ignore;

      if (col_a >= cols_eff) begin
         col_b = 9'd0;
         row_b = row_a + 10'd1;
      end else begin
         col_b = col_a;
         row_b = row_a;
      end
      scroll_en = (row_b >= {1'b0, rows_eff});

      rx = COORD_W'(BORDER) + COORD_W'(caret_col_ff) * COORD_W'(CELL_W);
      ry = COORD_W'(BORDER) + COORD_W'(caret_row_ff) * COORD_W'(CELL_H);
      rx_end = rx + COORD_W'(CELL_W);
      ry_end = ry + COORD_W'(CELL_H);
      glyph_rect.left = (rx > COORD_W'(COORD_MAX)) ? 13'(COORD_MAX) : 13'(rx);
      glyph_rect.top = (ry > COORD_W'(COORD_MAX)) ? 13'(COORD_MAX) : 13'(ry);
      glyph_rect.right = (rx_end > COORD_W'(EXTENT_MAX)) ? 13'(EXTENT_MAX) : 13'(rx_end);
      glyph_rect.bottom = (ry_end > COORD_W'(EXTENT_MAX)) ? 13'(EXTENT_MAX) : 13'(ry_end);

      scroll_w = (screen_width_ff > 13'(EXTENT_MAX)) ? 13'(EXTENT_MAX) : screen_width_ff;
      scroll_h = COORD_W'(rows_eff) * COORD_W'(CELL_H);
      scroll_bot = COORD_W'(BORDER) + scroll_h;
      scroll_rect.left = 13'd0;
      scroll_rect.top = (BORDER > COORD_MAX) ? 13'(COORD_MAX) : 13'(BORDER);
      scroll_rect.right = scroll_w;
      scroll_rect.bottom = (scroll_bot > COORD_W'(EXTENT_MAX)) ? 13'(EXTENT_MAX)
                                                              : 13'(scroll_bot);

      d1 = glyph_en ? rect_grow(dirty_ff, glyph_rect) : dirty_ff;
      d2 = scroll_en ? rect_grow(d1, scroll_rect) : d1;
      pres_rect = flush_req ? dirty_ff : d2;
      present_en = !rect_empty(pres_rect);

      c_glyph.kind = KIND_GLYPH;
      c_glyph.pos_x = glyph_rect.left[11:0];
      c_glyph.pos_y = glyph_rect.top[11:0];
      c_glyph.rect_w = 13'(CELL_W);
      c_glyph.rect_h = 13'(CELL_H);
      c_glyph.glyph = req_tdata;
      c_glyph.fore = fg_color_ff;
      c_glyph.back = bg_color_ff;
      c_glyph.last = 1'b0;

      c_scroll.kind = KIND_SCROLL;
      c_scroll.pos_x = 12'd0;
      c_scroll.pos_y = scroll_rect.top[11:0];
      c_scroll.rect_w = scroll_w;
      c_scroll.rect_h = (scroll_h > COORD_W'(EXTENT_MAX)) ? 13'(EXTENT_MAX) : 13'(scroll_h);
      c_scroll.glyph = 8'd0;
      c_scroll.fore = 24'd0;
      c_scroll.back = bg_color_ff;
      c_scroll.last = 1'b0;

      c_present.kind = KIND_PRESENT;
      c_present.pos_x = pres_rect.left[11:0];
      c_present.pos_y = pres_rect.top[11:0];
      c_present.rect_w = pres_rect.right - pres_rect.left;
      c_present.rect_h = pres_rect.bottom - pres_rect.top;
      c_present.glyph = 8'd0;
      c_present.fore = 24'd0;
      c_present.back = 24'd0;
      c_present.last = 1'b0;

      if (flush_req) begin
         n_cmd = present_en ? 2'd1 : 2'd0;
         c0 = c_present;
         c1 = c_present;
      end else if (put_active) begin
         n_cmd = 2'(glyph_en) + 2'(scroll_en) + 2'(is_lf && present_en);
         c0 = glyph_en ? c_glyph : (scroll_en ? c_scroll : c_present);
         c1 = glyph_en ? c_scroll : c_present;
      end else begin
         n_cmd = 2'd0;
         c0 = c_glyph;
         c1 = c_scroll;
      end
      c0.last = (n_cmd == 2'd1);
      c1.last = 1'b1;

      caret_col_in = caret_col_ff;
      caret_row_in = caret_row_ff;
      dirty_in = dirty_ff;
      if (accept && flush_req) begin
         dirty_in = '0;
      end else if (accept && put_active) begin
         caret_col_in = col_b[7:0];
         caret_row_in = scroll_en ? (rows_eff[7:0] - 8'd1) : row_b[7:0];
         dirty_in = is_lf ? '0 : d2;
      end

      base = count_ff - 2'(pop);
      for (int i = 0; i < 3; i++) begin
         queue_in[i] = (pop && i < 2) ? queue_ff[(i < 2) ? i + 1 : i] : queue_ff[i];
         if (accept && n_cmd != 2'd0 && base == 2'(i)) queue_in[i] = c0;
         if (accept && n_cmd == 2'd2 && base + 2'd1 == 2'(i)) queue_in[i] = c1;
      end
      count_in = base + (accept ? n_cmd : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_cols_ff <= 8'd80;
         text_rows_ff <= 8'd25;
         screen_width_ff <= 13'd640;
         console_enable_ff <= 1'b0;
         fg_color_ff <= 24'd13161440;
         bg_color_ff <= 24'd724500;
         caret_col_ff <= 8'd0;
         caret_row_ff <= 8'd0;
         dirty_ff <= '0;
         count_ff <= 2'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TEXT_COLS: text_cols_ff <= csr_wdata[7:0];
               REG_TEXT_ROWS: text_rows_ff <= csr_wdata[7:0];
               REG_SCREEN_WIDTH: screen_width_ff <= csr_wdata[12:0];
               REG_CONSOLE_ENABLE: console_enable_ff <= csr_wdata[0];
               REG_FG_COLOR: fg_color_ff <= csr_wdata;
               REG_BG_COLOR: bg_color_ff <= csr_wdata;
               default: ;
            endcase
         end
         caret_col_ff <= caret_col_in;
         caret_row_ff <= caret_row_in;
         dirty_ff <= dirty_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) queue_ff[i] <= queue_in[i];
   end

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      accept && put_active |=> caret_row_ff < $past(rows_eff[7:0]))
      else $error("cursor row left the screen after a transaction");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      accept && put_active |=> caret_col_ff < $past(cols_eff[7:0]))
      else $error("cursor column left the screen after a transaction");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && flush_req |=> dirty_ff == '0)
      else $error("dirty rectangle not cleared by flush");

   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd1 |-> queue_ff[0].last)
      else $error("lone queued command is not marked last");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      accept && n_cmd == 2'd2 |-> count_ff - 2'(pop) <= 2'd1)
      else $error("command queue overflow");

endmodule

>>> tb/text_console_cursor_engine_tb.sv
// Self-checking testbench for the text console cursor engine with a predicting scoreboard.
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
   import tcce_pkg::*;

   localparam int CELL_W = 8;
   localparam int CELL_H = 16;
   localparam int BORDER = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic mode;
      logic [7:0] code;
   } console_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic req_tuser = MODE_PUT;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   kind_type rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = REG_TEXT_COLS;
   logic [23:0] csr_wdata = 24'h000000;

   // configuration and state mirrored by the predictor
   logic [7:0] cfg_cols = 8'd80;
   logic [7:0] cfg_rows = 8'd25;
   logic [12:0] cfg_width = 13'd640;
   logic cfg_enable = 1'b0;
   logic [23:0] cfg_fg = 24'd13161440;
   logic [23:0] cfg_bg = 24'd724500;
   logic [7:0] caret_row = 8'd0;
   logic [7:0] caret_col = 8'd0;
   logic [12:0] dirty_l = 13'd0;
   logic [12:0] dirty_t = 13'd0;
   logic [12:0] dirty_r = 13'd0;
   logic [12:0] dirty_b = 13'd0;

   cmd_type step_out [2];
   int step_n;
   cmd_type console_cmds [$];
   console_item_type char_backlog [$];
   console_item_type next_item;

   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned rx_cycle = 0;
   int unsigned hold_left = 0;
   int unsigned pattern_left = 0;
   int unsigned stall_pct = 0;

   text_console_cursor_engine u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned clip(int unsigned v, int unsigned m);
      return (v > m) ? m : v;
   endfunction

   function automatic void add_cmd(kind_type k, int unsigned x, int unsigned y, int unsigned w,
                                   int unsigned h, int unsigned g, int unsigned f,
                                   int unsigned b);
      cmd_type c;
      c.kind = k;
      c.pos_x = 12'(x);
      c.pos_y = 12'(y);
      c.rect_w = 13'(w);
      c.rect_h = 13'(h);
      c.glyph = 8'(g);
      c.fore = 24'(f);
      c.back = 24'(b);
      c.last = 1'b0;
      step_out[step_n] = c;
      step_n++;
   endfunction

   function automatic logic dirty_is_empty();
      return (dirty_r <= dirty_l) || (dirty_b <= dirty_t);
   endfunction

   function automatic void grow_dirty(int unsigned x0, int unsigned y0, int unsigned x1,
                                      int unsigned y1);
      if (dirty_is_empty()) begin
         dirty_l = 13'(x0);
         dirty_t = 13'(y0);
         dirty_r = 13'(x1);
         dirty_b = 13'(y1);
      end else begin
         if (x0 < dirty_l) dirty_l = 13'(x0);
         if (y0 < dirty_t) dirty_t = 13'(y0);
         if (x1 > dirty_r) dirty_r = 13'(x1);
         if (y1 > dirty_b) dirty_b = 13'(y1);
      end
   endfunction

   function automatic void present_dirty();
      if (!dirty_is_empty()) begin
         add_cmd(KIND_PRESENT, dirty_l, dirty_t, 32'(dirty_r) - 32'(dirty_l),
                 32'(dirty_b) - 32'(dirty_t), 0, 0, 0);
      end
      dirty_l = 13'd0;
      dirty_t = 13'd0;
      dirty_r = 13'd0;
      dirty_b = 13'd0;
   endfunction

   function automatic void predict_commands(logic mode, logic [7:0] ch);
      int unsigned cols;
      int unsigned rows;
      int unsigned col;
      int unsigned row;
      int unsigned rx;
      int unsigned ry;
      int unsigned w;
      int unsigned h;
      int unsigned top;
      logic skip;
      cols = (cfg_cols == 8'd0) ? 1 : cfg_cols;
      rows = (cfg_rows == 8'd0) ? 1 : cfg_rows;
      col = caret_col;
      row = caret_row;
      skip = 1'b0;
      step_n = 0;
      if (mode == MODE_FLUSH) begin
         present_dirty();
      end else if (cfg_enable) begin
         case (ch)
            CHAR_LF: begin
               col = 0;
               row++;
            end
            CHAR_CR: begin
               col = 0;
            end
            CHAR_TAB: begin
               col = (col + 8) & ~32'd7;
            end
            CHAR_BS: begin
               if (col > 0) col--;
            end
            default: begin
               if (ch < PRINT_MIN) begin
                  skip = 1'b1;
               end else begin
                  rx = BORDER + col * CELL_W;
                  ry = BORDER + row * CELL_H;
                  add_cmd(KIND_GLYPH, clip(rx, COORD_MAX), clip(ry, COORD_MAX), CELL_W, CELL_H,
                          ch, cfg_fg, cfg_bg);
                  grow_dirty(clip(rx, COORD_MAX), clip(ry, COORD_MAX),
                             clip(rx + CELL_W, EXTENT_MAX), clip(ry + CELL_H, EXTENT_MAX));
                  col++;
               end
            end
         endcase
         if (!skip) begin
            if (col >= cols) begin
               col = 0;
               row++;
            end
            if (row >= rows) begin
               w = clip(cfg_width, EXTENT_MAX);
               h = rows * CELL_H;
               top = clip(BORDER, COORD_MAX);
               add_cmd(KIND_SCROLL, 0, top, w, clip(h, EXTENT_MAX), 0, 0, cfg_bg);
               grow_dirty(0, top, w, clip(BORDER + h, EXTENT_MAX));
               row = rows - 1;
            end
            caret_col = 8'(col);
            caret_row = 8'(row);
            if (ch == CHAR_LF) present_dirty();
         end
      end
      if (step_n > 0) step_out[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) console_cmds.push_back(step_out[i]);
   endfunction

   // request driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_commands(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (char_backlog.size() != 0) begin
               next_item = char_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_item.mode;
               req_tdata <= next_item.code;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // command receiver: changing stall pattern plus a periodic long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         rx_cycle = rx_cycle + 1;
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if ((rx_cycle % 2500) == 400) begin
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  2: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
               pattern_left = $urandom_range(16, 200);
            end else begin
               pattern_left = pattern_left - 1;
            end
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t %s expected %0h actual %0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (console_cmds.size() == 0) begin
            $display("%0t unexpected command expected none actual kind %0d data %h", $time,
                     rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = console_cmds.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("pos_x", want.pos_x, rsp_tdata[11:0]);
            check_field("pos_y", want.pos_y, rsp_tdata[23:12]);
            check_field("rect_w", want.rect_w, rsp_tdata[36:24]);
            check_field("rect_h", want.rect_h, rsp_tdata[49:37]);
            check_field("glyph", want.glyph, rsp_tdata[57:50]);
            check_field("fore", want.fore, rsp_tdata[81:58]);
            check_field("back", want.back, rsp_tdata[105:82]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void push_item(logic mode, logic [7:0] code);
      console_item_type it;
      it.mode = mode;
      it.code = code;
      char_backlog.push_back(it);
   endfunction

   function automatic logic [7:0] random_char(int unsigned lf_pct);
      if ($urandom_range(0, 99) < lf_pct) return CHAR_LF;
      case ($urandom_range(0, 9))
         0: return CHAR_CR;
         1: return CHAR_TAB;
         2: return CHAR_BS;
         3: return 8'($urandom_range(0, 31));
         default: return 8'($urandom_range(32, 255));
      endcase
   endfunction

   function automatic logic [7:0] random_dim();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd255;
         3, 4, 5: return 8'($urandom_range(2, 12));
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [23:0] random_width();
      case ($urandom_range(0, 7))
         0: return 24'd0;
         1: return 24'd4096;
         2: return 24'd4097;
         3: return 24'd8191;
         4: return 24'($urandom_range(0, 24'hFFFFFF));
         default: return 24'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] cols, input logic [7:0] rows,
                                 input logic [23:0] width, input logic en,
                                 input logic [23:0] fg, input logic [23:0] bg);
      write_reg(REG_TEXT_COLS, {16'd0, cols});
      write_reg(REG_TEXT_ROWS, {16'd0, rows});
      write_reg(REG_SCREEN_WIDTH, width);
      write_reg(REG_CONSOLE_ENABLE, {23'd0, en});
      write_reg(REG_FG_COLOR, fg);
      write_reg(REG_BG_COLOR, bg);
      csr_we <= 1'b0;
      cfg_cols = cols;
      cfg_rows = rows;
      cfg_width = width[12:0];
      cfg_enable = en;
      cfg_fg = fg;
      cfg_bg = bg;
   endtask

   task automatic drain();
      while (char_backlog.size() != 0 || req_tvalid || console_cmds.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int unsigned lf_pct;
      int unsigned count;
      logic [7:0] cols;
      logic [7:0] rows;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: characters dropped, empty flush
      push_item(MODE_PUT, "A");
      push_item(MODE_PUT, CHAR_LF);
      push_item(MODE_FLUSH, 8'hFF);
      drain();

      // tiny screen: wrap, tab past the row end, ignored controls, scroll and present
      apply_settings(8'd4, 8'd2, 24'd4096, 1'b1, 24'hFFFFFF, 24'h000000);
      push_item(MODE_PUT, 8'h20);
      push_item(MODE_PUT, 8'hFF);
      push_item(MODE_PUT, CHAR_BS);
      push_item(MODE_PUT, CHAR_TAB);
      push_item(MODE_PUT, "x");
      push_item(MODE_PUT, CHAR_CR);
      push_item(MODE_PUT, 8'h00);
      push_item(MODE_PUT, 8'h1F);
      push_item(MODE_PUT, 8'h7F);
      push_item(MODE_PUT, "a");
      push_item(MODE_PUT, "b");
      push_item(MODE_PUT, "c");
      push_item(MODE_PUT, "d");
      push_item(MODE_PUT, "e");
      push_item(MODE_PUT, CHAR_LF);
      push_item(MODE_FLUSH, 8'h00);
      push_item(MODE_PUT, "q");
      drain();

      // flush still presents while disabled
      apply_settings(8'd4, 8'd2, 24'd4096, 1'b0, 24'hFFFFFF, 24'h000000);
      push_item(MODE_PUT, "r");
      push_item(MODE_FLUSH, 8'h55);
      drain();

      // zero columns and rows, oversized screen width
      apply_settings(8'd0, 8'd0, 24'd8191, 1'b1, 24'h000000, 24'hFFFFFF);
      push_item(MODE_PUT, "Z");
      push_item(MODE_PUT, "Y");
      push_item(MODE_PUT, CHAR_LF);
      push_item(MODE_FLUSH, 8'hAA);
      drain();

      for (int p = 0; p < 11; p++) begin
         cols = random_dim();
         rows = random_dim();
         lf_pct = $urandom_range(2, 30);
         count = 72;
         if (p == 3) begin
            rows = 8'd255;
            lf_pct = 50;
            count = 300;
         end else if (p == 4) begin
            cols = 8'd2;
            rows = 8'd3;
         end
         apply_settings(cols, rows, random_width(),
                        ($urandom_range(0, 7) != 0) || (p == 3) || (p == 4),
                        24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8) push_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
            else push_item(MODE_PUT, random_char(lf_pct));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && console_cmds.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
